// File: rtl/obdpid_pkg.sv
`timescale 1ns / 1ps

package obdpid_pkg;

    // Default width of the millisecond counter
    localparam int CLOCK_BITS_DFLT = 32;

    localparam int SCALED_W = 23;

    typedef logic [7:0]                 t_byte;
    typedef logic signed [SCALED_W-1:0] t_scaled;

    // Request types
    localparam logic [1:0] REQ_CHAR = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_NEW  = 2'd2;

    // Decoded mode 01 PIDs
    localparam t_byte PID_LOAD    = 8'h04;
    localparam t_byte PID_COOLANT = 8'h05;
    localparam t_byte PID_MAP     = 8'h0B;
    localparam t_byte PID_RPM     = 8'h0C;
    localparam t_byte PID_SPEED   = 8'h0D;
    localparam t_byte PID_IAT     = 8'h0F;
    localparam t_byte PID_MAF     = 8'h10;
    localparam t_byte PID_BOOST   = 8'h70;

    // Characters
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_LF    = 8'h0A;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_PROMPT = 8'h3E;
    localparam t_byte CH_FOUR  = 8'h34;
    localparam t_byte CH_ONE   = 8'h31;

    // Operands handed to the scaling unit
    typedef struct packed {
        t_byte pid;
        logic  match;
        t_byte a;
        t_byte b;
    } t_scale_in;

    typedef struct packed {
        logic    known;
        t_scaled value;
    } t_scale_out;

    // Nibble to upper-case hex digit
    function automatic t_byte hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + {4'b0, nib};
        end
        return 8'h37 + {4'b0, nib};
    endfunction

    // Upper-case hex digit to {ok, nibble}
    function automatic logic [4:0] hex_val(input t_byte c);
        logic [7:0] d;
        d = c - 8'h37;
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, c[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            return {1'b1, d[3:0]};
        end
        return 5'b0;
    endfunction

endpackage

// File: rtl/obdpid_ifs.sv
`timescale 1ns / 1ps

interface obdpid_req_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           req_type;
    obdpid_pkg::t_byte    char_code;
    obdpid_pkg::t_byte    expected_pid;

    modport source (output valid, req_type, char_code, expected_pid, input ready);
    modport sink   (input valid, req_type, char_code, expected_pid, output ready);
endinterface

interface obdpid_rsp_if;
    logic                 valid;
    logic                 ready;
    obdpid_pkg::t_byte    decoded_pid;
    logic                 match_found;
    logic                 pid_known;
    obdpid_pkg::t_byte    byte_a;
    obdpid_pkg::t_byte    byte_b;
    obdpid_pkg::t_scaled  scaled_value;
    logic [31:0]          last_run_ms;
    logic                 timer_running_flag;
    logic                 timer_armed_flag;

    modport source (output valid, decoded_pid, match_found, pid_known, byte_a, byte_b,
                    scaled_value, last_run_ms, timer_running_flag, timer_armed_flag,
                    input ready);
    modport sink   (input valid, decoded_pid, match_found, pid_known, byte_a, byte_b,
                    scaled_value, last_run_ms, timer_running_flag, timer_armed_flag,
                    output ready);
endinterface

interface obdpid_cfg_if;
    logic              valid;
    logic              ready;
    obdpid_pkg::t_byte data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/obdpid_scale.sv
`timescale 1ns / 1ps

// Mode 01 value scaling, 1/256 units, floor. One shared multiplier;
// constant divisions are reciprocal multiplies with a 24-bit shift.
module obdpid_scale (
    input  obdpid_pkg::t_scale_in  i_op,
    output obdpid_pkg::t_scale_out o_res
);

    localparam int SHIFT = 24;
    localparam int OP_W  = 16;
    localparam int K_W   = 31;
    localparam int PR_W  = OP_W + K_W;

    // ceil(2^24 * 25600/255), ceil(2^24 * 64/25), ceil(2^24 * 2/25)
    localparam logic [K_W-1:0] K_LOAD  = 31'd1684300901;
    localparam logic [K_W-1:0] K_64_25 = 31'd42949673;
    localparam logic [K_W-1:0] K_2_25  = 31'd1342178;

    logic [15:0]          w_x;
    logic [OP_W-1:0]      w_op;
    logic [K_W-1:0]       w_k;
    logic [PR_W-1:0]      w_prod;
    logic                 w_known;
    obdpid_pkg::t_scaled  w_val;

    assign w_x    = {i_op.a, i_op.b};
    assign w_prod = PR_W'(w_op) * PR_W'(w_k);

    always_comb begin
        w_op    = '0;
        w_k     = '0;
        w_known = 1'b1;
        w_val   = '0;
        unique case (i_op.pid)
            obdpid_pkg::PID_LOAD: begin
                w_op  = {8'b0, i_op.a};
                w_k   = K_LOAD;
                w_val = w_prod[SHIFT +: obdpid_pkg::SCALED_W];
            end
            obdpid_pkg::PID_COOLANT, obdpid_pkg::PID_IAT: begin
                w_val = $signed({7'b0, i_op.a, 8'b0}) - 23'sd10240;
            end
            obdpid_pkg::PID_MAP: begin
                // clamp below 100 kPa
                w_op  = (i_op.a > 8'd100) ? {8'b0, i_op.a - 8'd100} : '0;
                w_k   = K_64_25;
                w_val = w_prod[SHIFT +: obdpid_pkg::SCALED_W];
            end
            obdpid_pkg::PID_RPM: begin
                w_val = {1'b0, w_x, 6'b0};
            end
            obdpid_pkg::PID_SPEED: begin
                w_val = {7'b0, i_op.a, 8'b0};
            end
            obdpid_pkg::PID_MAF: begin
                w_op  = w_x;
                w_k   = K_64_25;
                w_val = w_prod[SHIFT +: obdpid_pkg::SCALED_W];
            end
            obdpid_pkg::PID_BOOST: begin
                w_op  = (w_x > 16'd3200) ? w_x - 16'd3200 : '0;
                w_k   = K_2_25;
                w_val = w_prod[SHIFT +: obdpid_pkg::SCALED_W];
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    assign o_res.known = w_known;
    assign o_res.value = i_op.match ? w_val : '0;

endmodule

// File: rtl/obd_pid_response_decoder.sv
`timescale 1ns / 1ps

// A '>' item lands in the input register, its result in the result register.
// Throughput: one item per cycle unless a held result stalls; the parser, the
// scaling multiplier and timer update all sit in the single stage between them.
// Reset (i_rst_n low, synchronous): parser cleared, PID 0, timer and ms
// counter zero, target speed 100 km/h, both pipeline registers empty.
module obd_pid_response_decoder #(
    parameter int CLOCK_BITS = obdpid_pkg::CLOCK_BITS_DFLT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    obdpid_cfg_if.sink          i_cfg,
    obdpid_req_if.sink          i_req,
    obdpid_rsp_if.source        o_rsp
);

    // elapsed time is checked against 32 bits at this width
    localparam int ELW = (CLOCK_BITS > 32) ? CLOCK_BITS : 32;

    typedef enum logic {
        PH_SEARCH,
        PH_CAPTURE
    } t_phase;

    // ---------------- configuration ----------------
    obdpid_pkg::t_byte r_target;

    assign i_cfg.ready = 1'b1;

    // ---------------- input register ----------------
    logic              r_in_valid;
    logic [1:0]        r_in_req;
    obdpid_pkg::t_byte r_in_char;
    obdpid_pkg::t_byte r_in_pid;
    logic              w_go;

    // stage moves when the result register is free or being drained
    assign w_go        = r_in_valid && (!o_rsp.valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_go;

    // ---------------- parser / timer state ----------------
    logic [31:0]           r_window,  n_window;
    t_phase                r_phase,   n_phase;
    logic [2:0]            r_digit,   n_digit;
    logic [1:0]            r_stop,    n_stop;
    obdpid_pkg::t_byte     r_held_a,  n_held_a;
    obdpid_pkg::t_byte     r_held_b,  n_held_b;
    obdpid_pkg::t_byte     r_wanted,  n_wanted;
    logic                  r_closed,  n_closed;
    logic [CLOCK_BITS-1:0] r_ms,      n_ms;
    logic [CLOCK_BITS-1:0] r_start,   n_start;
    logic                  r_active,  n_active;
    logic                  r_armed,   n_armed;
    logic [31:0]           r_last,    n_last;
    logic                  n_emit;

    // ---------------- character decode ----------------
    obdpid_pkg::t_byte w_up;
    logic              w_ws;
    logic              w_prompt;
    logic [31:0]       w_shift;
    logic [31:0]       w_want;
    logic [4:0]        w_hex;
    logic              w_which;

    // fold lower case letters
    assign w_up     = (r_in_char >= 8'h61 && r_in_char <= 8'h7A) ? r_in_char - 8'h20
                                                                 : r_in_char;
    assign w_ws     = (r_in_char == obdpid_pkg::CH_CR) || (r_in_char == obdpid_pkg::CH_LF)
                   || (r_in_char == obdpid_pkg::CH_SPACE);
    assign w_prompt = (r_in_char == obdpid_pkg::CH_PROMPT);
    assign w_shift  = {r_window[23:0], w_up};
    assign w_want   = {obdpid_pkg::CH_FOUR, obdpid_pkg::CH_ONE,
                       obdpid_pkg::hex_char(r_wanted[7:4]),
                       obdpid_pkg::hex_char(r_wanted[3:0])};
    assign w_hex    = obdpid_pkg::hex_val(w_up);
    assign w_which  = r_digit[1];   // digits 0,1 -> byte A, 2,3 -> byte B

    // ---------------- response fields ----------------
    logic                   w_match;
    obdpid_pkg::t_byte      w_a;
    obdpid_pkg::t_byte      w_b;
    obdpid_pkg::t_scale_in  w_sc_in;
    obdpid_pkg::t_scale_out w_sc_out;

    // echo found and at least byte A's two characters followed
    assign w_match = (r_phase == PH_CAPTURE) && (r_digit >= 3'd2);
    assign w_a     = w_match ? r_held_a : '0;
    assign w_b     = (w_match && r_digit[2]) ? r_held_b : '0;

    assign w_sc_in.pid   = r_wanted;
    assign w_sc_in.match = w_match;
    assign w_sc_in.a     = w_a;
    assign w_sc_in.b     = w_b;

    obdpid_scale u_scale (
        .i_op  (w_sc_in),
        .o_res (w_sc_out)
    );

    // ---------------- acceleration timer ----------------
    logic [CLOCK_BITS-1:0] w_elapsed;
    logic [ELW-1:0]        w_el_ext;
    logic [31:0]           w_el_sat;

    assign w_elapsed = r_ms - r_start;   // wraps with the counter
    assign w_el_ext  = ELW'(w_elapsed);
    assign w_el_sat  = (w_el_ext > ELW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w_el_ext[31:0];

    // ---------------- next state ----------------
    always_comb begin
        n_window = r_window;
        n_phase  = r_phase;
        n_digit  = r_digit;
        n_stop   = r_stop;
        n_held_a = r_held_a;
        n_held_b = r_held_b;
        n_wanted = r_wanted;
        n_closed = r_closed;
        n_ms     = r_ms;
        n_start  = r_start;
        n_active = r_active;
        n_armed  = r_armed;
        n_last   = r_last;
        n_emit   = 1'b0;
        if (w_go) begin
            unique case (r_in_req)
                obdpid_pkg::REQ_CHAR: begin
                    // after '>' every character is ignored until the next new-PID request
                    if (!r_closed && !w_ws) begin
                        if (w_prompt) begin
                            n_closed = 1'b1;
                            n_emit   = 1'b1;
                            if (w_match && r_wanted == obdpid_pkg::PID_SPEED) begin
                                priority if (w_a == 8'd0) begin
                                    n_armed  = 1'b1;
                                    n_active = 1'b0;
                                end else if (w_a < r_target && r_armed && !r_active) begin
                                    n_start  = r_ms;
                                    n_active = 1'b1;
                                    n_armed  = 1'b0;
                                end else if (w_a >= r_target && r_active) begin
                                    n_last   = w_el_sat;
                                    n_active = 1'b0;
                                    n_armed  = 1'b0;
                                end else begin
                                    n_active = r_active;
                                end
                            end
                        end else if (r_phase == PH_SEARCH) begin
                            n_window = w_shift;
                            if (w_shift == w_want) begin
                                n_phase = PH_CAPTURE;
                                n_digit = '0;
                            end
                        end else if (!r_digit[2]) begin
                            // a byte stops growing at its first non-hex digit
                            if (!r_stop[w_which]) begin
                                if (!w_hex[4]) begin
                                    n_stop[w_which] = 1'b1;
                                end else if (!w_which) begin
                                    n_held_a = {r_held_a[3:0], w_hex[3:0]};
                                end else begin
                                    n_held_b = {r_held_b[3:0], w_hex[3:0]};
                                end
                            end
                            n_digit = r_digit + 3'd1;
                        end
                    end
                end
                obdpid_pkg::REQ_TICK: begin
                    n_ms = r_ms + CLOCK_BITS'(1);
                end
                obdpid_pkg::REQ_NEW: begin
                    n_wanted = r_in_pid;
                    n_window = '0;
                    n_phase  = PH_SEARCH;
                    n_digit  = '0;
                    n_stop   = '0;
                    n_held_a = '0;
                    n_held_b = '0;
                    n_closed = 1'b0;
                end
                default: begin
                    // unused request code
                end
            endcase
        end
    end

    // ---------------- registers ----------------
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= 8'd100;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_window    <= '0;
            r_phase     <= PH_SEARCH;
            r_digit     <= '0;
            r_stop      <= '0;
            r_held_a    <= '0;
            r_held_b    <= '0;
            r_wanted    <= '0;
            r_closed    <= 1'b0;
            r_ms        <= '0;
            r_start     <= '0;
            r_active    <= 1'b0;
            r_armed     <= 1'b0;
            r_last      <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_target <= i_cfg.data;
            end
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_go) begin
                r_in_valid <= 1'b0;
            end
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            r_window <= n_window;
            r_phase  <= n_phase;
            r_digit  <= n_digit;
            r_stop   <= n_stop;
            r_held_a <= n_held_a;
            r_held_b <= n_held_b;
            r_wanted <= n_wanted;
            r_closed <= n_closed;
            r_ms     <= n_ms;
            r_start  <= n_start;
            r_active <= n_active;
            r_armed  <= n_armed;
            r_last   <= n_last;
        end
    end

    // payload registers
    obdpid_pkg::t_byte   r_o_pid;
    logic                r_o_match;
    logic                r_o_known;
    obdpid_pkg::t_byte   r_o_a;
    obdpid_pkg::t_byte   r_o_b;
    obdpid_pkg::t_scaled r_o_val;
    logic [31:0]         r_o_last;
    logic                r_o_running;
    logic                r_o_armed;

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_req  <= i_req.req_type;
            r_in_char <= i_req.char_code;
            r_in_pid  <= i_req.expected_pid;
        end
        if (n_emit) begin
            r_o_pid     <= r_wanted;
            r_o_match   <= w_match;
            r_o_known   <= w_sc_out.known;
            r_o_a       <= w_a;
            r_o_b       <= w_b;
            r_o_val     <= w_sc_out.value;
            r_o_last    <= n_last;
            r_o_running <= n_active;
            r_o_armed   <= n_armed;
        end
    end

    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.decoded_pid        = r_o_pid;
    assign o_rsp.match_found        = r_o_match;
    assign o_rsp.pid_known          = r_o_known;
    assign o_rsp.byte_a             = r_o_a;
    assign o_rsp.byte_b             = r_o_b;
    assign o_rsp.scaled_value       = r_o_val;
    assign o_rsp.last_run_ms        = r_o_last;
    assign o_rsp.timer_running_flag = r_o_running;
    assign o_rsp.timer_armed_flag   = r_o_armed;

    // ---------------- assertions ----------------
    // timer is never armed and running at once
    a_timer_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_active && r_armed))
        else $error("timer armed and running together");

    // no data digits are counted before the echo is found, never more than four
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase != PH_SEARCH) || (r_digit == 3'd0)) && (r_digit <= 3'd4))
        else $error("digit count out of range");

    // a fresh result always comes from a closed response
    a_emit_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> r_closed)
        else $error("result issued without prompt");

endmodule
